@@ sv/ufm_pkg.sv @@
// ----------------------------------------------------------------------------
// ufm_pkg
// Shared types and constants of the union-find spanning-tree cost engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ufm_pkg;

	localparam int NODE_COUNT = 16384;
	localparam int NODE_W     = 14;
	localparam int WEIGHT_W   = 32;
	localparam int TOTAL_W    = 48;
	localparam int ADDR_W     = $clog2(NODE_COUNT);

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(NODE_COUNT - 1);

	localparam logic REQ_CLEAR = 1'b0;
	localparam logic REQ_EDGE  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND,
		ST_COMP,
		ST_NEXT,
		ST_LINK
	} ufm_state_t;

	typedef struct packed {
		logic clr;
		logic add;
	} ufm_tot_ctrl_t;

	function automatic logic node_in_range(input logic [NODE_W-1:0] n);
		return 32'(n) < 32'(NODE_COUNT);
	endfunction

endpackage

`default_nettype wire

@@ sv/ufm_ram.sv @@
// ----------------------------------------------------------------------------
// ufm_ram
// Generic simple dual-port RAM with one write port and one registered read
// port. A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module ufm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/ufm_total.sv @@
// ----------------------------------------------------------------------------
// ufm_total
// Saturating accumulator that holds the running cost of all merging edges.
// ----------------------------------------------------------------------------
`default_nettype none

module ufm_total (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ufm_pkg::ufm_tot_ctrl_t           ctrl,
	input  wire logic [ufm_pkg::WEIGHT_W-1:0]     weight,
	output      logic [ufm_pkg::TOTAL_W-1:0]      total
);
	import ufm_pkg::*;

	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W:0]   sum;

	assign sum   = {1'b0, total_q} + (TOTAL_W + 1)'(weight);
	assign total = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctrl.clr) begin
			total_q <= '0;
		end else if (ctrl.add) begin
			total_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
		end
	end

	// The total never decreases between clears.
	assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.clr |=> total_q >= $past(total_q))
		else $error("total decreased without a clear");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clr |=> total_q == '0)
		else $error("total not zero after clear");

endmodule

`default_nettype wire

@@ sv/union_find_mst_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// union_find_mst_accumulator_core
// Disjoint-set engine that accumulates the cost of a Kruskal spanning forest.
// ----------------------------------------------------------------------------
// After reset and after every clear request the engine sweeps the parent
// memory, one entry per cycle, so busy stays high until the sweep ends; a
// clear request reports its result when the sweep ends. An edge request
// searches the root of node_a and then the root of node_b, and after each
// search compresses that path; every hop of the root search and every pointer
// rewrite of the path compression is one read of the parent memory, so the
// request's duration grows with the hop counts from node_a and node_b to their roots.
// Path compression keeps the hop counts small. An edge with a node out of
// range returns its result in the cycle after acceptance. Each request
// yields exactly one result, shown for a single cycle while done is high;
// the receiver has no way to hold it, so it must capture it then.
`default_nettype none

module union_find_mst_accumulator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output      logic                            busy,
	input  wire logic                            req_type,
	input  wire logic [ufm_pkg::WEIGHT_W-1:0]    weight,
	input  wire logic [ufm_pkg::NODE_W-1:0]      node_a,
	input  wire logic [ufm_pkg::NODE_W-1:0]      node_b,
	output      logic                            done,
	output      logic                            merged,
	output      logic [ufm_pkg::TOTAL_W-1:0]     total
);
	import ufm_pkg::*;

	ufm_state_t state_q, state_d;

	logic [ADDR_W-1:0]   clr_cnt_q;
	logic                clr_report_q;
	logic                done_q;
	logic                merged_q;
	logic                finish;
	logic                merged_d;

	logic [ADDR_W-1:0]   na_q, nb_q, r_q, cur_q, root_a_q;
	logic                side_q;
	logic [WEIGHT_W-1:0] weight_q;

	logic                ram_we, ram_re;
	logic [ADDR_W-1:0]   ram_waddr, ram_wdata, ram_raddr, rd_data;
	logic [ADDR_W-1:0]   node_cur;
	logic                root_hit;

	ufm_tot_ctrl_t       tot_ctrl;

	ufm_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(NODE_COUNT)
	) u_parent (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	ufm_total u_total (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (tot_ctrl),
		.weight(weight_q),
		.total (total)
	);

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign merged   = merged_q;
	assign node_cur = side_q ? nb_q : na_q;
	assign root_hit = (rd_data == r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = r_q;
		ram_re    = 1'b0;
		ram_raddr = r_q;
		tot_ctrl  = '0;
		finish    = 1'b0;
		merged_d  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = clr_cnt_q;
				if (clr_cnt_q == ADDR_LAST) begin
					state_d = ST_IDLE;
					finish  = clr_report_q;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_CLEAR) begin
						tot_ctrl.clr = 1'b1;
						state_d      = ST_CLEAR;
					end else if (node_in_range(node_a) && node_in_range(node_b)) begin
						ram_re    = 1'b1;
						ram_raddr = ADDR_W'(node_a);
						state_d   = ST_FIND;
					end else begin
						finish = 1'b1;
					end
				end
			end
			ST_FIND: begin
				if (root_hit) begin
					if (node_cur == r_q) begin
						state_d = side_q ? ST_LINK : ST_NEXT;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = node_cur;
						state_d   = ST_COMP;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = rd_data;
				end
			end
			ST_COMP: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				ram_wdata = r_q;
				if (root_hit) begin
					state_d = side_q ? ST_LINK : ST_NEXT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = rd_data;
				end
			end
			ST_NEXT: begin
				ram_re    = 1'b1;
				ram_raddr = nb_q;
				state_d   = ST_FIND;
			end
			ST_LINK: begin
				if (root_a_q != r_q) begin
					ram_we       = 1'b1;
					ram_waddr    = root_a_q;
					ram_wdata    = r_q;
					tot_ctrl.add = 1'b1;
					merged_d     = 1'b1;
				end
				finish  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			clr_report_q <= 1'b0;
			done_q       <= 1'b0;
			merged_q     <= 1'b0;
		end else begin
			done_q   <= finish;
			merged_q <= merged_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= (clr_cnt_q == ADDR_LAST) ? '0 : clr_cnt_q + 1'b1;
				if (clr_cnt_q == ADDR_LAST) begin
					clr_report_q <= 1'b0;
				end
			end else if (state_q == ST_IDLE && start && req_type == REQ_CLEAR) begin
				clr_cnt_q    <= '0;
				clr_report_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					na_q     <= ADDR_W'(node_a);
					nb_q     <= ADDR_W'(node_b);
					r_q      <= ADDR_W'(node_a);
					weight_q <= weight;
					side_q   <= 1'b0;
				end
			end
			ST_FIND: begin
				if (root_hit) begin
					cur_q <= node_cur;
					if (!side_q) begin
						root_a_q <= r_q;
					end
				end else begin
					r_q <= rd_data;
				end
			end
			ST_COMP: begin
				cur_q <= rd_data;
			end
			ST_NEXT: begin
				r_q    <= nb_q;
				side_q <= 1'b1;
			end
			ST_CLEAR, ST_LINK: begin
			end
			default: begin
			end
		endcase
	end

	// Path compression never rewrites the entry that it reads in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> ram_waddr != ram_raddr)
		else $error("parent write and read collide");

	assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !ram_we)
		else $error("parent memory written while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		merged |-> done)
		else $error("merged flag without a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINK && root_a_q != r_q) |=> done && merged)
		else $error("link did not report a merge");

endmodule

`default_nettype wire
